// ----- src/bss_pkg.sv -----
// ----------------------------------------------------------------------------
// bss_pkg
// Shared constants, codes and controller/datapath interface types for the
// bounded sequence store.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int DEPTH     = 16;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int VW        = 32;
  localparam int DIV_STEPS = VW - 1;
  localparam int DIV_W     = $clog2(DIV_STEPS + 1);

  // operation codes
  localparam logic [2:0] FN_APPEND  = 3'd0;
  localparam logic [2:0] FN_PREPEND = 3'd1;
  localparam logic [2:0] FN_SEARCH  = 3'd2;
  localparam logic [2:0] FN_REVERSE = 3'd3;
  localparam logic [2:0] FN_SORT    = 3'd4;
  localparam logic [2:0] FN_ROTATE  = 3'd5;
  localparam logic [2:0] FN_RD_FWD  = 3'd6;
  localparam logic [2:0] FN_RD_BWD  = 3'd7;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    WR_VAL,
    WR_A,
    WR_RDATA
  } wr_sel_e;

  typedef struct packed {
    logic          ld_in;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    wr_sel_e       wr_sel;
    logic          ld_a;
    logic          fc_inc;
    logic          div_start;
    logic          div_step;
    logic          found_chk;
    logic          emit;
    logic          emit_data;
    logic [1:0]    emit_status;
    logic          emit_last;
  } cmd_t;

  typedef struct packed {
    logic [2:0]    func;
    logic [CW-1:0] fc;
    logic          amt_ok;
    logic          gt;
    logic [CW-1:0] rem;
    logic          out_free;
  } sts_t;

endpackage

// ----- src/bss_ram.sv -----
// ----------------------------------------------------------------------------
// bss_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bss_dp.sv -----
// ----------------------------------------------------------------------------
// bss_dp
// Datapath: entry memory, fill count, operand registers, remainder unit
// and the result output register.
// ----------------------------------------------------------------------------
module bss_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bss_pkg::cmd_t           cmd_i,
  output bss_pkg::sts_t           sts_o,
  input  logic [2:0]              func_i,
  input  logic [bss_pkg::VW-1:0]  value_i,
  input  logic [bss_pkg::VW-1:0]  amt_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [bss_pkg::VW-1:0]  out_data_o,
  output logic                    out_found_o,
  output logic [1:0]              out_status_o,
  output logic [bss_pkg::CW-1:0]  out_occ_o,
  output logic                    out_last_o
);

  logic [2:0]               func_q;
  logic [bss_pkg::VW-1:0]   val_q, amt_q, a_q, wdata, rdata;
  logic [bss_pkg::CW-1:0]   fc_q, rem_q;
  logic [bss_pkg::CW:0]     rem_sh;
  logic                     found_q;
  logic                     ov_q;
  logic [bss_pkg::VW-1:0]   od_q;
  logic                     of_q, ol_q;
  logic [1:0]               os_q;
  logic [bss_pkg::CW-1:0]   oo_q;

  bss_ram #(.WIDTH(bss_pkg::VW), .DEPTH(bss_pkg::DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  // select write data
  always_comb begin
    case (cmd_i.wr_sel)
      bss_pkg::WR_VAL:   wdata = val_q;
      bss_pkg::WR_A:     wdata = a_q;
      bss_pkg::WR_RDATA: wdata = rdata;
      default:           wdata = val_q;
    endcase
  end

  // one restoring step of the remainder
  assign rem_sh = {rem_q, amt_q[bss_pkg::VW-2]};

  // operand registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      func_q <= func_i;
      val_q  <= value_i;
      amt_q  <= amt_i;
    end else if (cmd_i.div_step) begin
      amt_q  <= {amt_q[bss_pkg::VW-1], amt_q[bss_pkg::VW-3:0], 1'b0};
    end
    if (cmd_i.ld_a) begin
      a_q <= rdata;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, fc_q}) begin
        rem_q <= bss_pkg::CW'(rem_sh - {1'b0, fc_q});
      end else begin
        rem_q <= bss_pkg::CW'(rem_sh);
      end
    end
  end

  // fill count, search flag and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q    <= '0;
      found_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (cmd_i.fc_inc) begin
        fc_q <= fc_q + bss_pkg::CW'(1);
      end
      if (cmd_i.ld_in) begin
        found_q <= 1'b0;
      end else if (cmd_i.found_chk && (rdata == val_q)) begin
        found_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      od_q <= cmd_i.emit_data ? rdata : '0;
      of_q <= found_q;
      os_q <= cmd_i.emit_status;
      oo_q <= fc_q;
      ol_q <= cmd_i.emit_last;
    end
  end

  assign sts_o.func     = func_q;
  assign sts_o.fc       = fc_q;
  assign sts_o.amt_ok   = !amt_q[bss_pkg::VW-1] && (amt_q != '0);
  assign sts_o.gt       = ($signed(a_q) > $signed(rdata));
  assign sts_o.rem      = rem_q;
  assign sts_o.out_free = !ov_q || out_ready_i;

  assign out_valid_o  = ov_q;
  assign out_data_o   = od_q;
  assign out_found_o  = of_q;
  assign out_status_o = os_q;
  assign out_occ_o    = oo_q;
  assign out_last_o   = ol_q;

endmodule

// ----- src/bss_ctrl.sv -----
// ----------------------------------------------------------------------------
// bss_ctrl
// Controller: sequences each operation over the entry memory as a series
// of read, compare and write steps.
// ----------------------------------------------------------------------------
module bss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bss_pkg::sts_t sts_i,
  output bss_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_PRE_RD, S_PRE_WR, S_PRE_HEAD, S_SRCH_RD, S_SRCH_CMP,
    S_REV, S_REV_A, S_REV_B, S_REV_C, S_SORT_START, S_SORT_LD, S_SORT_RD,
    S_SORT_CMP, S_SORT_END, S_DIV, S_ROT_SET, S_RD_ISSUE, S_RD_EMIT, S_EMIT
  } state_e;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_FINAL  = 2'd2;

  state_e                  state_q, state_d;
  logic [bss_pkg::CW-1:0]  p_q, p_d, lo_q, lo_d, hi_q, hi_d, fcm1, bidx;
  logic [1:0]              ph_q, ph_d, st_q, st_d;
  logic                    swp_q, swp_d;
  logic [bss_pkg::DIV_W-1:0] cnt_q, cnt_d;

  assign fcm1 = sts_i.fc - bss_pkg::CW'(1);
  assign bidx = fcm1 - p_q;
  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    ph_d    = ph_q;
    st_d    = st_q;
    swp_d   = swp_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.wr_sel = bss_pkg::WR_VAL;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          st_d        = bss_pkg::STAT_OK;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_EMIT;
        case (sts_i.func)
          bss_pkg::FN_APPEND: begin
            if (sts_i.fc == bss_pkg::CW'(bss_pkg::DEPTH)) begin
              st_d = bss_pkg::STAT_FULL;
            end else begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_addr = sts_i.fc[bss_pkg::AW-1:0];
              cmd_o.fc_inc  = 1'b1;
            end
          end
          bss_pkg::FN_PREPEND: begin
            if (sts_i.fc == bss_pkg::CW'(bss_pkg::DEPTH)) begin
              st_d = bss_pkg::STAT_FULL;
            end else if (sts_i.fc == '0) begin
              state_d = S_PRE_HEAD;
            end else begin
              p_d     = sts_i.fc;
              state_d = S_PRE_RD;
            end
          end
          bss_pkg::FN_SEARCH: begin
            if (sts_i.fc != '0) begin
              p_d     = '0;
              state_d = S_SRCH_RD;
            end
          end
          bss_pkg::FN_REVERSE: begin
            if (sts_i.fc > bss_pkg::CW'(1)) begin
              lo_d    = '0;
              hi_d    = fcm1;
              ph_d    = PH_FINAL;
              state_d = S_REV;
            end
          end
          bss_pkg::FN_SORT: begin
            if (sts_i.fc > bss_pkg::CW'(1)) begin
              state_d = S_SORT_START;
            end
          end
          bss_pkg::FN_ROTATE: begin
            if (sts_i.fc != '0 && sts_i.amt_ok) begin
              cmd_o.div_start = 1'b1;
              cnt_d           = '0;
              state_d         = S_DIV;
            end
          end
          default: begin
            if (sts_i.fc == '0) begin
              st_d = bss_pkg::STAT_EMPTY;
            end else begin
              p_d     = '0;
              state_d = S_RD_ISSUE;
            end
          end
        endcase
      end
      // shift entries up by one, from the end toward the front
      S_PRE_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = fcm1[bss_pkg::AW-1:0] - (fcm1[bss_pkg::AW-1:0] - (p_q[bss_pkg::AW-1:0]
                        - bss_pkg::AW'(1)));
        state_d       = S_PRE_WR;
      end
      S_PRE_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = p_q[bss_pkg::AW-1:0];
        cmd_o.wr_sel  = bss_pkg::WR_RDATA;
        p_d           = p_q - bss_pkg::CW'(1);
        state_d       = (p_q == bss_pkg::CW'(1)) ? S_PRE_HEAD : S_PRE_RD;
      end
      S_PRE_HEAD: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = '0;
        cmd_o.fc_inc  = 1'b1;
        state_d       = S_EMIT;
      end
      // compare each entry with the search value
      S_SRCH_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = p_q[bss_pkg::AW-1:0];
        state_d       = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        cmd_o.found_chk = 1'b1;
        p_d             = p_q + bss_pkg::CW'(1);
        state_d         = (p_q == fcm1) ? S_EMIT : S_SRCH_RD;
      end
      // reverse the span lo..hi by swapping from both ends
      S_REV: begin
        if (lo_q < hi_q) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = lo_q[bss_pkg::AW-1:0];
          state_d       = S_REV_A;
        end else begin
          case (ph_q)
            PH_FIRST: begin
              lo_d = sts_i.rem;
              hi_d = fcm1;
              ph_d = PH_SECOND;
            end
            PH_SECOND: begin
              lo_d = '0;
              hi_d = fcm1;
              ph_d = PH_FINAL;
            end
            default: state_d = S_EMIT;
          endcase
        end
      end
      S_REV_A: begin
        cmd_o.ld_a    = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = hi_q[bss_pkg::AW-1:0];
        state_d       = S_REV_B;
      end
      S_REV_B: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = lo_q[bss_pkg::AW-1:0];
        cmd_o.wr_sel  = bss_pkg::WR_RDATA;
        state_d       = S_REV_C;
      end
      S_REV_C: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = hi_q[bss_pkg::AW-1:0];
        cmd_o.wr_sel  = bss_pkg::WR_A;
        lo_d          = lo_q + bss_pkg::CW'(1);
        hi_d          = hi_q - bss_pkg::CW'(1);
        state_d       = S_REV;
      end
      // bubble pass carrying the larger value in the a register
      S_SORT_START: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = '0;
        swp_d         = 1'b0;
        state_d       = S_SORT_LD;
      end
      S_SORT_LD: begin
        cmd_o.ld_a = 1'b1;
        p_d        = bss_pkg::CW'(1);
        state_d    = S_SORT_RD;
      end
      S_SORT_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = p_q[bss_pkg::AW-1:0];
        state_d       = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = p_q[bss_pkg::AW-1:0] - bss_pkg::AW'(1);
        if (sts_i.gt) begin
          cmd_o.wr_sel = bss_pkg::WR_RDATA;
          swp_d        = 1'b1;
        end else begin
          cmd_o.wr_sel = bss_pkg::WR_A;
          cmd_o.ld_a   = 1'b1;
        end
        p_d     = p_q + bss_pkg::CW'(1);
        state_d = (p_q == fcm1) ? S_SORT_END : S_SORT_RD;
      end
      S_SORT_END: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = fcm1[bss_pkg::AW-1:0];
        cmd_o.wr_sel  = bss_pkg::WR_A;
        state_d       = swp_q ? S_SORT_START : S_EMIT;
      end
      // reduce the rotate count modulo the fill count
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + bss_pkg::DIV_W'(1);
        if (cnt_q == bss_pkg::DIV_W'(bss_pkg::DIV_STEPS - 1)) begin
          state_d = S_ROT_SET;
        end
      end
      // rotate by three reversals
      S_ROT_SET: begin
        if (sts_i.rem == '0) begin
          state_d = S_EMIT;
        end else begin
          lo_d    = '0;
          hi_d    = sts_i.rem - bss_pkg::CW'(1);
          ph_d    = PH_FIRST;
          state_d = S_REV;
        end
      end
      // readout, one entry per transfer
      S_RD_ISSUE: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = (sts_i.func == bss_pkg::FN_RD_FWD) ? p_q[bss_pkg::AW-1:0]
                                                           : bidx[bss_pkg::AW-1:0];
        state_d       = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_data   = 1'b1;
          cmd_o.emit_status = bss_pkg::STAT_OK;
          cmd_o.emit_last   = (p_q == fcm1);
          p_d               = p_q + bss_pkg::CW'(1);
          state_d           = (p_q == fcm1) ? S_IDLE : S_RD_ISSUE;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = st_q;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold state and sequencing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      p_q     <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      ph_q    <= PH_FINAL;
      st_q    <= bss_pkg::STAT_OK;
      swp_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      ph_q    <= ph_d;
      st_q    <= st_d;
      swp_q   <= swp_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- src/bounded_sequence_store_unit.sv -----
// ----------------------------------------------------------------------------
// bounded_sequence_store_unit
// Operations: push/search/reverse and readout run as RAM read and write steps,
// sort takes up to DEPTH bubble passes, rotate a remainder reduction plus three
// reversals; all steps go through the one RAM port pair.
// Throughput: one operation at a time; the next is taken after the last
// transfer has been loaded into the output register.
// Reset clears control and fill count; entries stay undefined and unread.
// ----------------------------------------------------------------------------
module bounded_sequence_store_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // value[31:0], shift_amount[63:32]
  input  logic [2:0]  s_axis_tuser_i,   // func[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // data[31:0], found[32], status[34:33],
                                        // occupancy[39:35]
  output logic        m_axis_tlast_o
);

  bss_pkg::cmd_t             cmd;
  bss_pkg::sts_t             sts;
  logic [bss_pkg::VW-1:0]    odata;
  logic                      ofound;
  logic [1:0]                ostatus;
  logic [bss_pkg::CW-1:0]    oocc;

  bss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bss_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (s_axis_tuser_i),
    .value_i      (s_axis_tdata_i[31:0]),
    .amt_i        (s_axis_tdata_i[63:32]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (odata),
    .out_found_o  (ofound),
    .out_status_o (ostatus),
    .out_occ_o    (oocc),
    .out_last_o   (m_axis_tlast_o)
  );

  // pack result fields
  assign m_axis_tdata_o = {oocc, ostatus, ofound, odata};

endmodule

// ----- bench/bounded_sequence_store_checker.sv -----
// ----------------------------------------------------------------------------
// bounded_sequence_store_checker
// Watches both stream channels of the sequence store, keeps a shadow copy of
// the stored entries, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module bounded_sequence_store_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [63:0] s_axis_tdata_i,   // value[31:0], shift_amount[63:32]
  input  logic [2:0]  s_axis_tuser_i,   // func[2:0]
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,   // data[31:0], found[32], status[34:33],
                                        // occupancy[39:35]
  input  logic        m_axis_tlast_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);

  typedef struct packed {
    logic [31:0] data;
    logic        found;
    logic [1:0]  status;
    logic [4:0]  occupancy;
    logic        last;
  } store_result_t;

  logic signed [31:0] shadow_q [bss_pkg::DEPTH];
  int                 shadow_fill;
  store_result_t      expected_q [$];

  // Queue one result with the current occupancy
  function automatic void push_result(logic [31:0] d, logic f, logic [1:0] s, logic l);
    store_result_t r;
    r.data = d; r.found = f; r.status = s;
    r.occupancy = 5'(shadow_fill); r.last = l;
    expected_q.push_back(r);
  endfunction

  // Apply one operation to the shadow store and queue its results
  function automatic void predict_operation(logic [2:0] fn, logic signed [31:0] val,
                                            logic signed [31:0] amt);
    logic signed [31:0] tmp [bss_pkg::DEPTH];
    logic signed [31:0] t;
    logic               hit, swapped;
    logic [1:0]         st;
    int                 n;
    hit = 1'b0;
    st  = bss_pkg::STAT_OK;
    case (fn)
      bss_pkg::FN_APPEND, bss_pkg::FN_PREPEND: begin
        if (shadow_fill >= bss_pkg::DEPTH) begin
          st = bss_pkg::STAT_FULL;
        end else if (fn == bss_pkg::FN_APPEND) begin
          shadow_q[shadow_fill] = val;
          shadow_fill++;
        end else begin
          for (int i = shadow_fill; i > 0; i--) shadow_q[i] = shadow_q[i-1];
          shadow_q[0] = val;
          shadow_fill++;
        end
      end
      bss_pkg::FN_SEARCH: begin
        for (int i = 0; i < shadow_fill; i++) if (shadow_q[i] == val) hit = 1'b1;
      end
      bss_pkg::FN_REVERSE: begin
        for (int i = 0; i < shadow_fill / 2; i++) begin
          t = shadow_q[i];
          shadow_q[i] = shadow_q[shadow_fill-1-i];
          shadow_q[shadow_fill-1-i] = t;
        end
      end
      bss_pkg::FN_SORT: begin
        do begin
          swapped = 1'b0;
          for (int i = 0; i + 1 < shadow_fill; i++) begin
            if (shadow_q[i] > shadow_q[i+1]) begin
              t = shadow_q[i]; shadow_q[i] = shadow_q[i+1]; shadow_q[i+1] = t;
              swapped = 1'b1;
            end
          end
        end while (swapped);
      end
      bss_pkg::FN_ROTATE: begin
        if (shadow_fill > 0 && amt > 0) begin
          n = amt % shadow_fill;
          for (int i = 0; i < shadow_fill; i++) tmp[i] = shadow_q[(i + n) % shadow_fill];
          for (int i = 0; i < shadow_fill; i++) shadow_q[i] = tmp[i];
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          push_result('0, 1'b0, bss_pkg::STAT_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_fill; i++)
            push_result(fn == bss_pkg::FN_RD_FWD ? shadow_q[i] : shadow_q[shadow_fill-1-i],
                        1'b0, bss_pkg::STAT_OK, i + 1 == shadow_fill);
        end
        return;
      end
    endcase
    push_result('0, hit, st, 1'b1);
  endfunction

  // Predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    store_result_t want;
    if (!rst_ni) begin
      shadow_fill    = 0;
      fail_count_o   = 0;
      result_count_o = 0;
      expected_q.delete();
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_operation(s_axis_tuser_i, s_axis_tdata_i[31:0], s_axis_tdata_i[63:32]);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        result_count_o++;
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer: tdata %h", m_axis_tdata_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata_i[31:0] !== want.data) begin
            $error("data: expected %h actual %h", want.data, m_axis_tdata_i[31:0]);
            fail_count_o++;
          end
          if (m_axis_tdata_i[32] !== want.found) begin
            $error("found: expected %b actual %b", want.found, m_axis_tdata_i[32]);
            fail_count_o++;
          end
          if (m_axis_tdata_i[34:33] !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, m_axis_tdata_i[34:33]);
            fail_count_o++;
          end
          if (m_axis_tdata_i[39:35] !== want.occupancy) begin
            $error("occupancy: expected %0d actual %0d", want.occupancy,
                   m_axis_tdata_i[39:35]);
            fail_count_o++;
          end
          if (m_axis_tlast_i !== want.last) begin
            $error("last: expected %b actual %b", want.last, m_axis_tlast_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ----- bench/bounded_sequence_store_unit_tb.sv -----
// ----------------------------------------------------------------------------
// bounded_sequence_store_unit_tb
// Drives directed and random operations into the sequence store with random
// idle bursts on both channels and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module bounded_sequence_store_unit_tb;

  localparam int RANDOM_OPS  = 380;
  localparam int CALM_OPS    = 57;
  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = bss_pkg::FN_APPEND;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  int          fail_count, pending, result_count;
  int          op_count;
  bit          calm_phase;
  int          stall_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  bounded_sequence_store_unit dut (.*);

  bounded_sequence_store_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i, .s_axis_tuser_i, .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o), .m_axis_tlast_i(m_axis_tlast_o),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  // Stall the result channel in short random bursts
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 3);
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Hold one operation until its transfer
  task automatic send_op(logic [2:0] fn, logic [31:0] val, logic [31:0] amt);
    int gap;
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= fn;
    s_axis_tdata_i  <= {amt, val};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
    op_count++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_shift();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom;
      2: return 32'h7FFF_FFFF;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  initial begin
    int fn_roll;
    logic [2:0] fn;
    op_count     = 0;
    calm_phase   = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty store corner cases
    send_op(bss_pkg::FN_RD_FWD, '0, '0);
    send_op(bss_pkg::FN_RD_BWD, '0, '0);
    send_op(bss_pkg::FN_SORT, '0, '0);
    send_op(bss_pkg::FN_REVERSE, '0, '0);
    send_op(bss_pkg::FN_SEARCH, '0, '0);
    send_op(bss_pkg::FN_ROTATE, '0, 32'd3);
    // Extremes, then fill to capacity and overflow both ends
    send_op(bss_pkg::FN_APPEND, 32'h7FFF_FFFF, '0);
    send_op(bss_pkg::FN_PREPEND, 32'h8000_0000, '0);
    send_op(bss_pkg::FN_SEARCH, 32'h8000_0000, '0);
    send_op(bss_pkg::FN_SORT, '0, '0);
    for (int i = 0; i < 14; i++)
      send_op(i[0] ? bss_pkg::FN_APPEND : bss_pkg::FN_PREPEND, $urandom, '0);
    send_op(bss_pkg::FN_APPEND, 32'hFFFF_FFFF, '0);
    send_op(bss_pkg::FN_PREPEND, 32'h0, '0);
    send_op(bss_pkg::FN_ROTATE, '0, 32'h7FFF_FFFF);
    send_op(bss_pkg::FN_ROTATE, '0, 32'hFFFF_FFFF);
    send_op(bss_pkg::FN_ROTATE, '0, 32'd0);
    send_op(bss_pkg::FN_REVERSE, '0, '0);
    send_op(bss_pkg::FN_SORT, '0, '0);
    send_op(bss_pkg::FN_RD_FWD, '0, '0);
    send_op(bss_pkg::FN_RD_BWD, '0, '0);

    // Random operations, readouts rarer so the store stays varied
    for (int k = 0; k < RANDOM_OPS + CALM_OPS; k++) begin
      if (k == RANDOM_OPS) calm_phase = 1'b1;
      fn_roll = $urandom_range(0, 15);
      if (fn_roll < 5) fn = bss_pkg::FN_APPEND;
      else if (fn_roll < 8) fn = bss_pkg::FN_PREPEND;
      else fn = 3'($urandom_range(2, 7));
      send_op(fn, pick_value(), pick_shift());
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain and let the pipeline settle
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d operations and %0d result transfers", op_count, result_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bss_pkg.sv
src/bss_ram.sv
src/bss_dp.sv
src/bss_ctrl.sv
src/bounded_sequence_store_unit.sv
bench/bounded_sequence_store_checker.sv
bench/bounded_sequence_store_unit_tb.sv
